[rtl/aes128_pkg.sv]
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// S-boxes, GF(2^8) helpers, round transforms and key schedule steps.
// ----------------------------------------------------------------------------
package aes128_pkg;

  localparam int unsigned RoundCount = 10;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } reg_e;

  // byte i of the block sits at blk[15-i]
  typedef logic [15:0][7:0] blk_t;
  typedef logic [3:0]       rnd_t;

  typedef struct packed {
    op_e  op;
    blk_t state;
    blk_t key;
  } beat_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // round constant used to derive round key r from round key r-1
  function automatic logic [7:0] rcon(input rnd_t r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1B;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] bget(input blk_t b, input int i);
    return b[15-i];
  endfunction

  function automatic blk_t sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[15-(4*c+r)] = FWD_SBOX[bget(s, 4*((c+r)%4)+r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[15-(4*((c+r)%4)+r)] = INV_SBOX[bget(s, 4*c+r)];
      end
    end
    return t;
  endfunction

  function automatic blk_t mix(input blk_t s);
    blk_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = bget(s, 4*c);
      a1 = bget(s, 4*c+1);
      a2 = bget(s, 4*c+2);
      a3 = bget(s, 4*c+3);
      t[15-(4*c)]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[15-(4*c+1)] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[15-(4*c+2)] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[15-(4*c+3)] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t t;
    logic [3:0][7:0] a, x2, x4, x8;
    logic [3:0][7:0] m9, m11, m13, m14;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a[k]   = bget(s, 4*c+k);
        x2[k]  = xt(a[k]);
        x4[k]  = xt(x2[k]);
        x8[k]  = xt(x4[k]);
        m9[k]  = x8[k] ^ a[k];
        m11[k] = x8[k] ^ x2[k] ^ a[k];
        m13[k] = x8[k] ^ x4[k] ^ a[k];
        m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      t[15-(4*c)]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[15-(4*c+1)] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[15-(4*c+2)] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[15-(4*c+3)] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

  // RotWord, SubWord and Rcon applied to the last word of a round key
  function automatic logic [31:0] key_core(input logic [31:0] w, input logic [7:0] rc);
    return {FWD_SBOX[w[23:16]] ^ rc, FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]],
            FWD_SBOX[w[31:24]]};
  endfunction

  function automatic blk_t key_fwd(input blk_t k, input rnd_t r);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[15:12] ^ key_core(k[3:0], rcon(r));
    n1 = k[11:8] ^ n0;
    n2 = k[7:4] ^ n1;
    n3 = k[3:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic blk_t key_inv(input blk_t k, input rnd_t r);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[3:0] ^ k[7:4];
    w2 = k[7:4] ^ k[11:8];
    w1 = k[11:8] ^ k[15:12];
    w0 = k[15:12] ^ key_core(w3, rcon(r));
    return {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/aes128_enc_stage.sv]
// ----------------------------------------------------------------------------
// AES-128 forward stage
// Expands the next round key; applies one encryption round to encrypt beats.
// ----------------------------------------------------------------------------
module aes128_enc_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aes128_pkg::rnd_t  round_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  aes128_pkg::beat_t beat_i,
  output logic              valid_o,
  input  logic              ready_i,
  output aes128_pkg::beat_t beat_o
);
  import aes128_pkg::*;

  logic  valid_q;
  beat_t beat_q, beat_d;
  blk_t  rk, st;

  // advance when empty or when the next stage takes our beat
  assign ready_o = !valid_q || ready_i;

  // one forward round: SubBytes, ShiftRows, MixColumns except last, AddRoundKey
  always_comb begin
    rk = key_fwd(beat_i.key, round_i);
    st = sub_shift(beat_i.state);
    if (round_i != rnd_t'(RoundCount)) begin
      st = mix(st);
    end
    st = st ^ rk;
    beat_d.op    = beat_i.op;
    beat_d.key   = rk;
    beat_d.state = (beat_i.op == OP_ENCRYPT) ? st : beat_i.state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

[rtl/aes128_dec_stage.sv]
// ----------------------------------------------------------------------------
// AES-128 inverse stage
// Steps the round key back by one; applies one decryption round to decrypt beats.
// ----------------------------------------------------------------------------
module aes128_dec_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aes128_pkg::rnd_t  round_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  aes128_pkg::beat_t beat_i,
  output logic              valid_o,
  input  logic              ready_i,
  output aes128_pkg::beat_t beat_o
);
  import aes128_pkg::*;

  logic  valid_q;
  beat_t beat_q, beat_d;
  blk_t  rk, st;

  assign ready_o = !valid_q || ready_i;

  // AddRoundKey, InvMixColumns except first, InvShiftRows and InvSubBytes;
  // the round-one stage also adds the cipher key
  always_comb begin
    rk = key_inv(beat_i.key, round_i);
    st = beat_i.state ^ beat_i.key;
    if (round_i != rnd_t'(RoundCount)) begin
      st = inv_mix(st);
    end
    st = inv_sub_shift(st);
    if (round_i == rnd_t'(1)) begin
      st = st ^ rk;
    end
    beat_d.op    = beat_i.op;
    beat_d.key   = rk;
    beat_d.state = (beat_i.op == OP_DECRYPT) ? st : beat_i.state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

[rtl/aes128_block_cipher.sv]
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Fully unrolled round pipeline, one block per cycle in either direction when not stalled.
// ----------------------------------------------------------------------------
// Accepts one 128-bit block per clock unless stalled and returns it encrypted
// or decrypted under the key in registers 0 (key bytes 0-7) and 1 (key bytes
// 8-15). Every block travels 20 register stages whatever its direction, and
// results leave in input order. The first ten stages expand the round keys
// forward and carry out the encryption rounds; the last ten walk the key
// schedule back and carry out the decryption rounds. Each stage holds its beat
// only while the one after it is full and stalled, so bubbles close up and a
// stalled output does not stop input until the pipe is full. Write the key
// only while no block is in flight.
// ----------------------------------------------------------------------------
module aes128_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] data_high_i,
  input  logic [63:0] data_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  import aes128_pkg::*;

  localparam int unsigned Stages = 2 * RoundCount;

  logic [63:0] key_high_q, key_low_q;
  beat_t       beat   [Stages+1];
  logic        valid  [Stages+1];
  logic        ready  [Stages+1];
  blk_t        cfg_key, in_blk;

  // hold the key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_index_i))
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // initial AddRoundKey for encryption on the way in
  assign cfg_key = {key_high_q, key_low_q};
  assign in_blk  = {data_high_i, data_low_i};

  always_comb begin
    beat[0].op    = op_e'(operation_i);
    beat[0].key   = cfg_key;
    beat[0].state = (op_e'(operation_i) == OP_ENCRYPT) ? (in_blk ^ cfg_key) : in_blk;
  end

  assign valid[0]   = in_valid_i;
  assign in_stall_o = !ready[0];

  for (genvar k = 1; k <= RoundCount; k++) begin : g_enc
    aes128_enc_stage u_stage (
      .clk_i,
      .rst_ni,
      .round_i (rnd_t'(k)),
      .valid_i (valid[k-1]),
      .ready_o (ready[k-1]),
      .beat_i  (beat[k-1]),
      .valid_o (valid[k]),
      .ready_i (ready[k]),
      .beat_o  (beat[k])
    );
  end

  for (genvar k = RoundCount + 1; k <= Stages; k++) begin : g_dec
    aes128_dec_stage u_stage (
      .clk_i,
      .rst_ni,
      .round_i (rnd_t'(Stages + 1 - k)),
      .valid_i (valid[k-1]),
      .ready_o (ready[k-1]),
      .beat_i  (beat[k-1]),
      .valid_o (valid[k]),
      .ready_i (ready[k]),
      .beat_o  (beat[k])
    );
  end

  // last stage is the output register
  assign ready[Stages]  = !out_stall_i;
  assign out_valid_o    = valid[Stages];
  assign result_high_o  = beat[Stages].state[15:8];
  assign result_low_o   = beat[Stages].state[7:0];

endmodule

[dv/tb_aes128_block_cipher.sv]
// ----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Drives blocks in both directions under several keys, with random idling on
// both channels. Every result is compared against a behavioral cipher model.
// ----------------------------------------------------------------------------
module tb_aes128_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import aes128_pkg::*;

  localparam logic [1:0]  KeyBadIdx  = 2'd2;
  localparam int unsigned Latency    = 20;
  localparam int unsigned RandItems  = 730;
  localparam int unsigned IdleLimit  = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [63:0] data_high_i = '0;
  logic [63:0] data_low_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes128_block_cipher u_top (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Cipher model: own copy of the key, byte i of a block at b[i]
  // ---------------------------------------------------------------------
  typedef logic [7:0] bytes16_t [16];

  logic [63:0] key_hi_q, key_lo_q;
  bytes16_t    round_keys [11];

  const logic [7:0] SBOX_F [256] = FWD_SBOX;
  logic [7:0]       sbox_r [256];

  function automatic logic [7:0] gdbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, int unsigned b);
    logic [7:0] acc;
    acc = '0;
    while (b != 0) begin
      if (b[0]) acc ^= a;
      a = gdbl(a);
      b >>= 1;
    end
    return acc;
  endfunction

  task automatic build_round_keys();
    logic [7:0] w [44][4];
    logic [7:0] t [4];
    logic [7:0] tmp, rc;
    logic [127:0] k;
    rc = 8'h01;
    k = {key_hi_q, key_lo_q};
    for (int i = 0; i < 16; i++) w[i/4][i%4] = k[127-8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
        for (int j = 0; j < 4; j++) t[j] = SBOX_F[t[j]];
        t[0] ^= rc;
        rc = gdbl(rc);
      end
      for (int j = 0; j < 4; j++) w[i][j] = w[i-4][j] ^ t[j];
    end
    for (int r = 0; r < 11; r++)
      for (int j = 0; j < 16; j++) round_keys[r][j] = w[4*r + j/4][j%4];
  endtask

  function automatic void add_key(ref bytes16_t s, input int r);
    for (int i = 0; i < 16; i++) s[i] ^= round_keys[r][i];
  endfunction

  function automatic void sub_rows(ref bytes16_t s, input bit inv);
    bytes16_t t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inv) t[4*((c+r)%4)+r] = sbox_r[s[4*c+r]];
        else     t[4*c+r] = SBOX_F[s[4*((c+r)%4)+r]];
    s = t;
  endfunction

  function automatic void mix_cols(ref bytes16_t s, input int unsigned m [4]);
    logic [7:0] a [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[4*c+k];
      for (int r = 0; r < 4; r++)
        s[4*c+r] = gmul(a[0], m[(4-r)%4]) ^ gmul(a[1], m[(5-r)%4]) ^
                   gmul(a[2], m[(6-r)%4]) ^ gmul(a[3], m[(7-r)%4]);
    end
  endfunction

  function automatic logic [127:0] cipher_block(op_e op, logic [127:0] blk);
    bytes16_t s;
    logic [127:0] res;
    int unsigned fwd_m [4] = '{2, 3, 1, 1};
    int unsigned inv_m [4] = '{14, 11, 13, 9};
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    if (op == OP_ENCRYPT) begin
      add_key(s, 0);
      for (int r = 1; r < 10; r++) begin
        sub_rows(s, 1'b0);
        mix_cols(s, fwd_m);
        add_key(s, r);
      end
      sub_rows(s, 1'b0);
      add_key(s, 10);
    end else begin
      add_key(s, 10);
      sub_rows(s, 1'b1);
      for (int r = 9; r > 0; r--) begin
        add_key(s, r);
        mix_cols(s, inv_m);
        sub_rows(s, 1'b1);
      end
      add_key(s, 0);
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Expected results and checking
  // ---------------------------------------------------------------------
  logic [127:0] expected_blocks [$];
  int unsigned  fail_count = 0;
  int unsigned  beats_in = 0, beats_out = 0, enc_count = 0, dec_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  rx_hold = 0;
  int unsigned  rx_wait = 0;

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (out_valid_o && !out_stall_i) begin
      beats_out++;
      if (expected_blocks.size() == 0) begin
        $display("%0t: unexpected beat %h_%h", $time, result_high_o, result_low_o);
        fail_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (result_high_o !== want[127:64]) begin
          $display("%0t: result_high expected %h actual %h", $time, want[127:64],
                   result_high_o);
          fail_count++;
        end
        if (result_low_o !== want[63:0]) begin
          $display("%0t: result_low expected %h actual %h", $time, want[63:0],
                   result_low_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall for a randomly drawn wait after each beat, plus one long hold-off
  always @(posedge clk_i) begin
    if (rx_hold > 0) rx_hold--;
    if (out_valid_o && !out_stall_i) rx_wait = $urandom_range(0, 9);
    else if (rx_wait > 0) rx_wait--;
    out_stall_i <= (rx_hold > 0) || (rx_wait > 0);
  end

  // ---------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else if (idx == REG_KEY_LOW) key_lo_q = val;
    build_round_keys();
  endtask

  task automatic drain_pipe();
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // gap: idle cycles before the beat; want: typed-in result or zero if none.
  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_block(op_e op, logic [63:0] hi, logic [63:0] lo, int unsigned gap,
                            bit has_want = 1'b0, logic [127:0] want = '0);
    logic [127:0] pred;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    data_high_i <= hi;
    data_low_i <= lo;
    do @(posedge clk_i); while (in_stall_o);
    pred = cipher_block(op, {hi, lo});
    if (has_want && pred !== want) begin
      $display("%0t: model expected %h actual %h", $time, want, pred);
      fail_count++;
    end
    expected_blocks.push_back(has_want ? want : pred);
    beats_in++;
    if (op == OP_ENCRYPT) enc_count++; else dec_count++;
  endtask

  // drop valid at the edge that took the last beat
  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // Directed stimulus table
  typedef struct {
    op_e          op;
    logic [63:0]  hi, lo;
    bit           has_want;
    logic [127:0] want;
  } vec_t;

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    vec_t dir_zero_key [4];
    vec_t dir_std_key [4];
    logic [63:0] kh, kl;
    op_e op;
    int unsigned mode;

    for (int i = 0; i < 256; i++) sbox_r[SBOX_F[i]] = i[7:0];
    key_hi_q = '0;
    key_lo_q = '0;
    build_round_keys();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key of all zeros, known vectors
    dir_zero_key = '{
      '{OP_ENCRYPT, 64'h0, 64'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{OP_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 128'h0},
      '{OP_ENCRYPT, '1, '1, 1'b0, '0},
      '{OP_DECRYPT, '1, '1, 1'b0, '0}};
    foreach (dir_zero_key[i])
      send_block(dir_zero_key[i].op, dir_zero_key[i].hi, dir_zero_key[i].lo,
                 i % 3, dir_zero_key[i].has_want, dir_zero_key[i].want);
    end_burst();
    drain_pipe();

    // Out-of-range index must be ignored
    write_reg(KeyBadIdx, 64'hdeadbeefcafef00d);
    send_block(OP_ENCRYPT, 64'h0, 64'h0, 0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
    end_burst();
    drain_pipe();

    // Standard key vectors
    write_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    dir_std_key = '{
      '{OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1,
        128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      '{OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
        128'h00112233445566778899aabbccddeeff},
      '{OP_ENCRYPT, 64'h8000000000000000, 64'h1, 1'b0, '0},
      '{OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, '0}};
    foreach (dir_std_key[i])
      send_block(dir_std_key[i].op, dir_std_key[i].hi, dir_std_key[i].lo, 0,
                 dir_std_key[i].has_want, dir_std_key[i].want);
    end_burst();
    drain_pipe();

    // All-ones key, walking single bits
    write_reg(REG_KEY_HIGH, '1);
    write_reg(REG_KEY_LOW, '1);
    for (int i = 0; i < 8; i++)
      send_block(op_e'(i[0]), 64'h1 << (i * 9), 64'h1 << (63 - i * 7), 0);
    end_burst();
    drain_pipe();

    // Random phases, each with its own key
    for (int ph = 0; ph < 5; ph++) begin
      kh = {$urandom, $urandom};
      kl = {$urandom, $urandom};
      if (ph == 4) begin
        kh = '0;
      end
      write_reg(REG_KEY_HIGH, kh);
      write_reg(REG_KEY_LOW, kl);

      // Long receiver hold-off while the sender keeps offering blocks
      if (ph == 1) rx_hold = 200;

      for (int n = 0; n < RandItems / 5; n++) begin
        op = op_e'($urandom_range(0, 1));
        mode = $urandom_range(0, 3);
        send_block(op, {$urandom, $urandom}, {$urandom, $urandom},
                   (mode == 0) ? 0 : $urandom_range(0, 9));
        // Sender pauses once until everything has come back
        if (ph == 2 && n == 40) begin
          end_burst();
          while (expected_blocks.size() != 0) @(posedge clk_i);
        end
      end
      end_burst();
      drain_pipe();
    end

    $display("Blocks sent %0d (encrypt %0d, decrypt %0d), results checked %0d,",
             beats_in, enc_count, dec_count, beats_out);
    $display("over zero, standard, all-ones and random keys with idling on both sides.");
    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
